// ----- hdl/fea_pkg.sv -----
// Shared constants and types of the free extent allocator.
`default_nettype none
package fea_pkg;
  localparam int MaxExtents = 64;
  localparam int AddrBits   = 16;
  localparam int IdxBits    = $clog2(MaxExtents);
  localparam int CntBits    = $clog2(MaxExtents + 1);
  localparam int SizeBits   = AddrBits + 1;
  localparam int EntBits    = AddrBits + SizeBits;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_READ   = 8'b00000010,
    S_SCAN   = 8'b00000100,
    S_DECIDE = 8'b00001000,
    S_SHIFTR = 8'b00010000,
    S_SHIFTW = 8'b00100000,
    S_FIX    = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/fea_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
`default_nettype none
module fea_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/free_extent_allocator.sv -----
// Top level of the free extent allocator: control sequencer around the extent table.
//
// Keeps a sorted table of disjoint free extents (base, size) in one RAM.
// Input channel in_*: in_tuser = req_type (0 allocate, 1 free), in_tdata packs
// range_start and range_length. Each request answers with one result on out_*:
// out_tdata packs status (0 ok, 1 range miss, 2 table full) and extent_count.
// Configuration channel cfg_*: writing total_size resets the table to a single
// extent [0, total_size), or to none when it is 0; sizes above 2^16 saturate.
// A write is taken only while no request is in flight and no result waits.
// Throughput: one request at a time. A request scans the table one entry per
// cycle (one RAM read port), then moves entries one by one, each read and then
// written back, when an insert or removal shifts the tail. A zero length or a
// free past the space end goes straight to its result without a table scan.
// Reset writes entry 0 as [0, 65536); no clearing pass is needed since only
// entries below the count are read.
// The result waits in an output register; while the receiver stalls, the
// block takes one more request, works it through and holds its result until
// the waiting one is taken.
`default_nettype none
module free_extent_allocator
  import fea_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [15:0] range_start, [32:16] range_length
  input  wire         in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [1:0] status, [8:2] extent_count
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [16:0] cfg_data
);
  localparam logic [SizeBits-1:0] FullSpace = SizeBits'(1) << AddrBits;

  state_t state_r, state_nxt;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  logic [SizeBits-1:0] total_r, total_nxt;
  logic                typ_r, typ_nxt;
  logic [SizeBits-1:0] st_r, st_nxt;     // start, widened
  logic [SizeBits-1:0] len_r, len_nxt;
  logic [IdxBits:0]    idx_r, idx_nxt;   // scan position
  logic [EntBits-1:0]  prev_r, prev_nxt; // entry before idx
  logic [EntBits-1:0]  cur_r, cur_nxt;   // entry at idx (if idx < cnt)
  logic [IdxBits:0]    mv_r, mv_nxt;     // shift pointer
  logic                dir_r, dir_nxt;   // 1 shift up (insert), 0 shift down
  logic [EntBits-1:0]  ins_r, ins_nxt;   // entry to write at the fix point
  logic [IdxBits:0]    fix_r, fix_nxt;
  logic [1:0]          stat_r, stat_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [CntBits+1:0]  res_r, res_nxt;   // {extent_count, status} on offer

  logic               we;
  logic [IdxBits-1:0] waddr, raddr;
  logic [EntBits-1:0] wdata, rdata;

  fea_ram #(.Width(EntBits), .Depth(MaxExtents)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [EntBits-1:0] mk(input logic [SizeBits-1:0] b,
                                            input logic [SizeBits-1:0] s);
    mk = {s, b[AddrBits-1:0]};
  endfunction

  logic [SizeBits-1:0] cb, cs, ce, pb, ps, pe, rb, en;
  logic [SizeBits:0]   en_x;             // range end, one bit wider than a size
  logic [SizeBits-1:0] cfg_sat;
  logic                has_cur, has_prev;

  always_comb begin
    cb = {1'b0, cur_r[AddrBits-1:0]};
    cs = cur_r[EntBits-1:AddrBits];
    ce = cb + cs;
    pb = {1'b0, prev_r[AddrBits-1:0]};
    ps = prev_r[EntBits-1:AddrBits];
    pe = pb + ps;
    rb = {1'b0, rdata[AddrBits-1:0]};
    en_x = {1'b0, st_r} + {1'b0, len_r};
    en = en_x[SizeBits-1:0];
    has_cur  = ({1'b0, idx_r} < {1'b0, cnt_r});
    has_prev = (idx_r != '0);
    cfg_sat  = (cfg_data > FullSpace) ? FullSpace : cfg_data;
  end

  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, res_r};

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; total_nxt = total_r;
    typ_nxt = typ_r; st_nxt = st_r; len_nxt = len_r; idx_nxt = idx_r;
    prev_nxt = prev_r; cur_nxt = cur_r; mv_nxt = mv_r; dir_nxt = dir_r;
    ins_nxt = ins_r; fix_nxt = fix_r; stat_nxt = stat_r; ovalid_nxt = ovalid_r;
    res_nxt = res_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          // restart the table as one extent
          total_nxt = cfg_sat;
          we = 1'b1; waddr = '0; wdata = mk('0, cfg_sat);
          cnt_nxt = (cfg_sat != '0) ? CntBits'(1) : '0;
        end else if (in_tvalid && in_tready) begin
          typ_nxt = in_tuser;
          st_nxt  = {1'b0, in_tdata[15:0]};
          len_nxt = in_tdata[32:16];
          idx_nxt = '0;
          stat_nxt = StatOk;
          if (in_tdata[32:16] == '0) begin
            state_nxt = S_DONE;
          end else if (in_tuser == ReqFree &&
                       ({2'b0, in_tdata[15:0]} + {1'b0, in_tdata[32:16]}) >
                       {1'b0, total_r}) begin
            stat_nxt = StatMiss; state_nxt = S_DONE;
          end else begin
            raddr = '0; state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // read data for idx arrives next cycle
        raddr = idx_r[IdxBits-1:0];
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cur_nxt = rdata;
        if (!has_cur) begin
          state_nxt = S_DECIDE;
        end else if (typ_r == ReqAlloc) begin
          if (rb <= st_r &&
              en_x <= {1'b0, rb} + {1'b0, rdata[EntBits-1:AddrBits]}) begin
            state_nxt = S_DECIDE;
          end else begin
            prev_nxt = rdata; idx_nxt = idx_r + 1'b1;
            raddr = idx_nxt[IdxBits-1:0]; state_nxt = S_SCAN;
          end
        end else begin
          if (rb < st_r) begin
            prev_nxt = rdata; idx_nxt = idx_r + 1'b1;
            raddr = idx_nxt[IdxBits-1:0]; state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
        if (state_nxt == S_SCAN && ({1'b0, idx_nxt} >= {1'b0, cnt_r}))
          state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (typ_r == ReqAlloc) begin
          if (!has_cur) begin
            stat_nxt = StatMiss;
          end else if (st_r == cb && en_x == {1'b0, ce}) begin
            // drop the whole extent: shift down from idx
            cnt_nxt = cnt_r - 1'b1;
            mv_nxt = idx_r; dir_nxt = 1'b0;
            state_nxt = S_SHIFTR;
            if ({1'b0, idx_r} + 1'b1 >= {1'b0, cnt_r}) state_nxt = S_DONE;
          end else if (st_r == cb) begin
            we = 1'b1; waddr = idx_r[IdxBits-1:0]; wdata = mk(en, ce - en);
          end else if (en_x == {1'b0, ce}) begin
            we = 1'b1; waddr = idx_r[IdxBits-1:0]; wdata = mk(cb, st_r - cb);
          end else if (cnt_r >= CntBits'(MaxExtents)) begin
            stat_nxt = StatFull;
          end else begin
            we = 1'b1; waddr = idx_r[IdxBits-1:0]; wdata = mk(cb, st_r - cb);
            ins_nxt = mk(en, ce - en); fix_nxt = idx_r + 1'b1;
            // open a gap at fix by moving entries [fix, cnt) up one, top first
            cnt_nxt = cnt_r + 1'b1; dir_nxt = 1'b1;
            mv_nxt  = (IdxBits+1)'(cnt_r);
            state_nxt = ((IdxBits+1)'(cnt_r) == fix_nxt) ? S_FIX : S_SHIFTR;
          end
        end else begin
          if (has_prev && pe > st_r) begin
            stat_nxt = StatMiss;
          end else if (has_cur && {1'b0, cb} < en_x) begin
            stat_nxt = StatMiss;
          end else if (has_prev && pe == st_r && has_cur && {1'b0, cb} == en_x) begin
            we = 1'b1; waddr = IdxBits'(idx_r - 1'b1);
            wdata = mk(pb, ps + len_r + cs);
            cnt_nxt = cnt_r - 1'b1;
            mv_nxt = idx_r; dir_nxt = 1'b0;
            state_nxt = S_SHIFTR;
            if ({1'b0, idx_r} + 1'b1 >= {1'b0, cnt_r}) state_nxt = S_DONE;
          end else if (has_prev && pe == st_r) begin
            we = 1'b1; waddr = IdxBits'(idx_r - 1'b1); wdata = mk(pb, ps + len_r);
          end else if (has_cur && {1'b0, cb} == en_x) begin
            we = 1'b1; waddr = idx_r[IdxBits-1:0]; wdata = mk(st_r, cs + len_r);
          end else if (cnt_r >= CntBits'(MaxExtents)) begin
            stat_nxt = StatFull;
          end else begin
            ins_nxt = mk(st_r, len_r); fix_nxt = idx_r;
            // open a gap at fix by moving entries [fix, cnt) up one, top first
            cnt_nxt = cnt_r + 1'b1; dir_nxt = 1'b1;
            mv_nxt  = (IdxBits+1)'(cnt_r);
            state_nxt = ((IdxBits+1)'(cnt_r) == fix_nxt) ? S_FIX : S_SHIFTR;
          end
        end
      end
      S_SHIFTR: begin
        // read source entry of the move
        raddr = dir_r ? IdxBits'(mv_r - 1'b1) : IdxBits'(mv_r + 1'b1);
        state_nxt = S_SHIFTW;
      end
      S_SHIFTW: begin
        we = 1'b1; waddr = mv_r[IdxBits-1:0]; wdata = rdata;
        if (dir_r) begin
          mv_nxt = mv_r - 1'b1;
          state_nxt = (mv_r - 1'b1 == fix_r) ? S_FIX : S_SHIFTR;
        end else begin
          mv_nxt = mv_r + 1'b1;
          state_nxt = ({1'b0, mv_r} + 1'b1 >= {1'b0, cnt_r}) ? S_DONE : S_SHIFTR;
        end
      end
      S_FIX: begin
        we = 1'b1; waddr = fix_r[IdxBits-1:0]; wdata = ins_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result still waits
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          res_nxt = {cnt_r, stat_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // load entry 0 with the full space while reset is held
    if (!rst_n) begin
      we = 1'b1; waddr = '0; wdata = mk('0, FullSpace);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= CntBits'(1); total_r <= FullSpace;
      ovalid_r <= 1'b0; stat_r <= StatOk; res_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; total_r <= total_nxt;
      ovalid_r <= ovalid_nxt; stat_r <= stat_nxt; res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    typ_r <= typ_nxt; st_r <= st_nxt; len_r <= len_nxt; idx_r <= idx_nxt;
    prev_r <= prev_nxt; cur_r <= cur_nxt; mv_r <= mv_nxt; dir_r <= dir_nxt;
    ins_r <= ins_nxt; fix_r <= fix_nxt;
  end
endmodule
`default_nettype wire
